// ===== rtl/fcwp_pkg.sv =====
// Shared types, constants and character-class helpers for the file command word parser.
// No dependencies; every other file in rtl/ imports this package.
package fcwp_pkg;

   localparam int WORD_W    = 32;
   localparam int NUM_CODES = 5;
   localparam int CSR_IDX_W = $clog2(NUM_CODES);

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_OPEN_CODE  = csr_idx_type'(0);
   localparam csr_idx_type CSR_CLOSE_CODE = csr_idx_type'(1);
   localparam csr_idx_type CSR_READ_CODE  = csr_idx_type'(2);
   localparam csr_idx_type CSR_WRITE_CODE = csr_idx_type'(3);
   localparam csr_idx_type CSR_SEEK_CODE  = csr_idx_type'(4);

   localparam word_type OPEN_CODE_RESET  = 32'd0;
   localparam word_type CLOSE_CODE_RESET = 32'd1;
   localparam word_type READ_CODE_RESET  = 32'd2;
   localparam word_type WRITE_CODE_RESET = 32'd3;
   localparam word_type SEEK_CODE_RESET  = 32'd4;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef enum logic [3:0] {
      ST_OPCODE  = 4'd0,
      ST_SIZE    = 4'd1,
      ST_DATA    = 4'd2,
      ST_DESC    = 4'd3,
      ST_OFFSET  = 4'd4,
      ST_FLAGS   = 4'd5,
      ST_FINISH  = 4'd6,
      ST_BUFADDR = 4'd7,
      ST_INVALID = 4'd8
   } parse_state_type;

   typedef enum logic [2:0] {
      FN_OPEN    = 3'd0,
      FN_CLOSE   = 3'd1,
      FN_READ    = 3'd2,
      FN_WRITE   = 3'd3,
      FN_SEEK    = 3'd4,
      FN_UNKNOWN = 3'd5
   } call_kind_type;

   typedef enum logic [2:0] {
      KIND_OPCODE  = 3'd0,
      KIND_SIZE    = 3'd1,
      KIND_BYTE    = 3'd2,
      KIND_DESC    = 3'd3,
      KIND_OFFSET  = 3'd4,
      KIND_FLAGS   = 3'd5,
      KIND_BUFADDR = 3'd6,
      KIND_NONE    = 3'd7
   } kind_type;

   typedef struct packed {
      parse_state_type parse_state;
      call_kind_type   func;
      word_type        bytes_taken;
      word_type        payload_length;
   } fsm_state_type;

   typedef struct packed {
      kind_type      kind;
      word_type      value;
      word_type      byte_index;
      call_kind_type func;
      logic          complete;
      logic          invalid;
   } result_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic is_path_char(input logic [7:0] c);
      return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39)) ||
             (c == CHAR_DOT) || (c == CHAR_SLASH);
   endfunction

endpackage

// ===== rtl/fcwp_codes.sv =====
// Opcode code registers written over the CSR port, and first-match opcode decode.
// Depends on fcwp_pkg.
module fcwp_codes (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  fcwp_pkg::csr_idx_type   csr_index,
   input  fcwp_pkg::word_type      csr_wdata,
   input  fcwp_pkg::word_type      word,
   output fcwp_pkg::call_kind_type func
);
   import fcwp_pkg::*;

   word_type codes_ff [NUM_CODES];

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff[CSR_OPEN_CODE]  <= OPEN_CODE_RESET;
         codes_ff[CSR_CLOSE_CODE] <= CLOSE_CODE_RESET;
         codes_ff[CSR_READ_CODE]  <= READ_CODE_RESET;
         codes_ff[CSR_WRITE_CODE] <= WRITE_CODE_RESET;
         codes_ff[CSR_SEEK_CODE]  <= SEEK_CODE_RESET;
      end else if (csr_write && (csr_index < csr_idx_type'(NUM_CODES))) begin
         codes_ff[csr_index] <= csr_wdata;
      end
   end

   // lowest index wins on shared codes
   always_comb begin
      func = FN_UNKNOWN;
      for (int i = NUM_CODES - 1; i >= 0; i--) begin
         if (codes_ff[i] == word) begin
            func = call_kind_type'(3'(i));
         end
      end
   end

endmodule

// ===== rtl/fcwp_classify.sv =====
// Parser state machine: next state and classified result for one command word.
// Depends on fcwp_pkg.
module fcwp_classify (
   input  logic                    op,
   input  fcwp_pkg::word_type      word,
   input  fcwp_pkg::call_kind_type decoded,
   input  fcwp_pkg::fsm_state_type cur,
   output fcwp_pkg::fsm_state_type nxt,
   output fcwp_pkg::result_type    res
);
   import fcwp_pkg::*;

   logic [7:0] data_byte;
   word_type   bytes_inc;
   logic       bad_byte;

   assign data_byte = word[7:0];
   assign bytes_inc = cur.bytes_taken + word_type'(1);
   assign bad_byte  = (cur.func == FN_OPEN) &&
                      ((cur.bytes_taken == '0) ? !is_letter(data_byte)
                                               : !is_path_char(data_byte));

   always_comb begin
      nxt = cur;
      if (op) begin
         nxt.parse_state    = ST_OPCODE;
         nxt.func           = FN_OPEN;
         nxt.bytes_taken    = '0;
         nxt.payload_length = '0;
      end else begin
         unique case (cur.parse_state)
            ST_OPCODE: begin
               nxt.func        = decoded;
               nxt.parse_state = (decoded == FN_OPEN) ? ST_SIZE : ST_DESC;
            end
            ST_SIZE: begin
               if (word == '0) begin
                  nxt.parse_state = ST_INVALID;
               end else begin
                  nxt.payload_length = word;
                  nxt.parse_state    = (cur.func == FN_READ) ? ST_BUFADDR : ST_DATA;
               end
            end
            ST_DATA: begin
               nxt.bytes_taken = bytes_inc;
               if (bad_byte) begin
                  nxt.parse_state = ST_INVALID;
               end else if (bytes_inc == cur.payload_length) begin
                  nxt.parse_state = (cur.func == FN_OPEN) ? ST_FLAGS : ST_FINISH;
               end
            end
            ST_DESC: begin
               if (cur.func == FN_SEEK) begin
                  nxt.parse_state = ST_OFFSET;
               end else if (cur.func == FN_CLOSE) begin
                  nxt.parse_state = ST_FINISH;
               end else if ((cur.func == FN_READ) || (cur.func == FN_WRITE)) begin
                  nxt.parse_state = ST_SIZE;
               end
            end
            ST_OFFSET:  nxt.parse_state = ST_FLAGS;
            ST_FLAGS:   nxt.parse_state = ST_FINISH;
            ST_BUFADDR: nxt.parse_state = ST_FINISH;
            default:    nxt.parse_state = ST_INVALID;
         endcase
      end
   end

   always_comb begin
      res.kind       = KIND_NONE;
      res.value      = '0;
      res.byte_index = '0;
      if (!op) begin
         unique case (cur.parse_state)
            ST_OPCODE: begin
               res.kind  = KIND_OPCODE;
               res.value = word;
            end
            ST_SIZE: begin
               res.kind  = KIND_SIZE;
               res.value = word;
            end
            ST_DATA: begin
               res.kind       = KIND_BYTE;
               res.value      = {{(WORD_W - 8){1'b0}}, data_byte};
               res.byte_index = cur.bytes_taken;
            end
            ST_DESC: begin
               res.kind  = KIND_DESC;
               res.value = word;
            end
            ST_OFFSET: begin
               res.kind  = KIND_OFFSET;
               res.value = word;
            end
            ST_FLAGS: begin
               res.kind  = KIND_FLAGS;
               res.value = word;
            end
            ST_BUFADDR: begin
               res.kind  = KIND_BUFADDR;
               res.value = word;
            end
            default: begin
               res.kind  = KIND_NONE;
               res.value = '0;
            end
         endcase
      end
      res.func     = nxt.func;
      res.complete = (nxt.parse_state == ST_FINISH);
      res.invalid  = (nxt.parse_state == ST_INVALID);
   end

endmodule

// ===== rtl/file_command_word_parser.sv =====
// Top level of the file command word parser: input register, parser state, result register.
// Depends on fcwp_pkg, fcwp_codes and fcwp_classify.
//
//   channel  direction  handshake              beat contents
//   req_     in         req_valid/req_ready    op, word
//   rsp_     out        rsp_valid/rsp_ready    field_kind, field_value, byte_index,
//                                              function_kind, complete, invalid
//   csr_     in         csr_write              csr_index, csr_wdata (no read-back)
//
// One word per cycle sustained while rsp_ready stays high; a beat passes through the input
// register (loaded by its accepting edge), then classification, then the result register,
// which presents it on rsp_. The parser state register updates when a word moves from the
// input register to the result register. A stalled rsp_ beat holds; the input register
// still takes one more beat, then req_ready drops until the result is taken.
// Synchronous reset clears the code registers to their defaults and the parser
// to awaiting opcode.
module file_command_word_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_field_kind,
   output logic [31:0] rsp_field_value,
   output logic [31:0] rsp_byte_index,
   output logic [2:0]  rsp_function_kind,
   output logic        rsp_complete,
   output logic        rsp_invalid,
   input  logic        csr_write,
   input  logic [fcwp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata
);
   import fcwp_pkg::*;

   logic          s1_valid_ff;
   logic          s1_op_ff;
   word_type      s1_word_ff;
   logic          rsp_valid_ff;
   result_type    rsp_ff;
   fsm_state_type state_ff;
   fsm_state_type state_in;
   result_type    result_in;
   call_kind_type decoded;
   logic          advance;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   fcwp_codes u_codes (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_idx_type'(csr_index)),
      .csr_wdata (word_type'(csr_wdata)),
      .word      (s1_word_ff),
      .func      (decoded)
   );

   fcwp_classify u_classify (
      .op      (s1_op_ff),
      .word    (s1_word_ff),
      .decoded (decoded),
      .cur     (state_ff),
      .nxt     (state_in),
      .res     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff   <= req_op;
         s1_word_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.parse_state    <= ST_OPCODE;
         state_ff.func           <= FN_OPEN;
         state_ff.bytes_taken    <= '0;
         state_ff.payload_length <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_field_kind    = rsp_ff.kind;
   assign rsp_field_value   = rsp_ff.value;
   assign rsp_byte_index    = rsp_ff.byte_index;
   assign rsp_function_kind = rsp_ff.func;
   assign rsp_complete      = rsp_ff.complete;
   assign rsp_invalid       = rsp_ff.invalid;

`ifndef SYNTH
   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> (state_ff.parse_state == ST_OPCODE) && !s1_valid_ff && !rsp_valid_ff)
      else $error("parser not in opcode state after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input register empty but req_ready low");

   a_done_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_complete && rsp_invalid))
      else $error("result flagged both complete and invalid");

   a_index_byte_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_field_kind != KIND_BYTE)) |-> (rsp_byte_index == '0))
      else $error("byte index nonzero on a non-byte beat");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_field_kind == KIND_NONE)) |-> (rsp_field_value == '0))
      else $error("field value nonzero on a none beat");
`endif

endmodule
